>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared codes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int OP_W    = 3;
  localparam int ST_W    = 2;
  localparam int ORDER_W = 4;
  localparam int REF_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_REF_GET = 3'd2;
  localparam logic [OP_W-1:0] OP_REF_INC = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISUSE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_END   = 2'd2;

  // field write enables of the page table
  typedef struct packed {
    logic nxt;
    logic prv;
    logic tag;
    logic cnt;
  } bpa_wmask_t;

endpackage

`default_nettype wire

>>> rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if / bpa_rsp_if
// Request and result channels of the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if #(
  parameter int PNB = 12
) ();
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::OP_W-1:0]      operation;
  logic [PNB-1:0]                page_number;
  logic [bpa_pkg::ORDER_W-1:0]   order;
  logic                          zone;

  modport source (output valid, output operation, output page_number, output order,
                  output zone, input ready);
  modport sink   (input valid, input operation, input page_number, input order,
                  input zone, output ready);
endinterface

interface bpa_rsp_if #(
  parameter int PNB = 12
) ();
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::ST_W-1:0]      status;
  logic [PNB-1:0]                block_page;
  logic [bpa_pkg::REF_W-1:0]     ref_count;
  logic                          released;
  logic [PNB:0]                  free_pages;

  modport source (output valid, output status, output block_page, output ref_count,
                  output released, output free_pages, input ready);
  modport sink   (input valid, input status, input block_page, input ref_count,
                  input released, input free_pages, output ready);
endinterface

`default_nettype wire

>>> rtl/bpa_mem.sv
// ----------------------------------------------------------------------------
// bpa_mem
// Page table: next/prev links, order tag and reference count per page.
// One read port (registered data, write forwarding), one field-masked write.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_mem #(
  parameter int AW = 12,
  parameter int LKW = 13,
  parameter int TW = 4
) (
  input  wire                          clk,
  input  wire  [AW-1:0]                rd_addr,
  output logic [LKW-1:0]               rd_nxt,
  output logic [LKW-1:0]               rd_prv,
  output logic [TW-1:0]                rd_tag,
  output logic [bpa_pkg::REF_W-1:0]    rd_cnt,
  input  wire                          wr_en,
  input  wire  [AW-1:0]                wr_addr,
  input  bpa_pkg::bpa_wmask_t          wr_mask,
  input  wire  [LKW-1:0]               wr_nxt,
  input  wire  [LKW-1:0]               wr_prv,
  input  wire  [TW-1:0]                wr_tag,
  input  wire  [bpa_pkg::REF_W-1:0]    wr_cnt
);

  localparam int DEPTH = 1 << AW;

  logic [LKW-1:0]            nxt_mem [DEPTH];
  logic [LKW-1:0]            prv_mem [DEPTH];
  logic [TW-1:0]             tag_mem [DEPTH];
  logic [bpa_pkg::REF_W-1:0] cnt_mem [DEPTH];

  logic hit;

  assign hit = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en && wr_mask.nxt) nxt_mem[wr_addr] <= wr_nxt;
    if (wr_en && wr_mask.prv) prv_mem[wr_addr] <= wr_prv;
    if (wr_en && wr_mask.tag) tag_mem[wr_addr] <= wr_tag;
    if (wr_en && wr_mask.cnt) cnt_mem[wr_addr] <= wr_cnt;
    rd_nxt <= (hit && wr_mask.nxt) ? wr_nxt : nxt_mem[rd_addr];
    rd_prv <= (hit && wr_mask.prv) ? wr_prv : prv_mem[rd_addr];
    rd_tag <= (hit && wr_mask.tag) ? wr_tag : tag_mem[rd_addr];
    rd_cnt <= (hit && wr_mask.cnt) ? wr_cnt : cnt_mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: list walks, unlink/link, split, merge and release over
// the page table, plus list heads, free-page total and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl #(
  parameter int PNB = 12,
  parameter int PAGE_COUNT = 4096
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [PNB:0]                 present_pages,
  input  wire  [PNB:0]                 zone_start_page,
  input  wire  [PNB:0]                 zone_end_page,
  bpa_req_if.sink                      in_req,
  bpa_rsp_if.source                    out_rsp,
  output logic [$clog2(PAGE_COUNT)-1:0] rd_addr,
  input  wire  [PNB:0]                 rd_nxt,
  input  wire  [PNB:0]                 rd_prv,
  input  wire  [((PNB < 15) ? 4 : 5)-1:0] rd_tag,
  input  wire  [bpa_pkg::REF_W-1:0]    rd_cnt,
  output logic                         wr_en,
  output logic [$clog2(PAGE_COUNT)-1:0] wr_addr,
  output bpa_pkg::bpa_wmask_t          wr_mask,
  output logic [PNB:0]                 wr_nxt,
  output logic [PNB:0]                 wr_prv,
  output logic [((PNB < 15) ? 4 : 5)-1:0] wr_tag,
  output logic [bpa_pkg::REF_W-1:0]    wr_cnt
);

  localparam int AW = $clog2(PAGE_COUNT);
  localparam int LW = $clog2(PNB + 1);
  localparam int TW = (PNB < 15) ? 4 : 5;
  localparam int WW = PNB + 1;
  localparam logic [TW-1:0] TAG_ALLOC = {TW{1'b1}};

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_START, S_REF, S_FIND, S_FWAIT,
    S_RM_RD, S_RM_LAT, S_RM_LNK, S_RM_PRV, S_RM_TAG,
    S_SPLIT, S_INS_A, S_INS_B,
    S_M_CHK, S_M_TST, S_M_NEXT, S_M_END,
    S_REL_DESC, S_REL_TST, S_REL_NEXT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  state_t rem_ret_r, rem_ret_nxt;
  state_t ins_ret_r, ins_ret_nxt;
  state_t mrg_ret_r, mrg_ret_nxt;

  logic [bpa_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [LW-1:0]             ord_r, ord_nxt;
  logic                      want_r, want_nxt;
  logic [LW-1:0]             lvl_r, lvl_nxt;
  logic [LW-1:0]             mord_r, mord_nxt;
  logic [PNB-1:0]            p_r, p_nxt;
  logic [PNB-1:0]            mh_r, mh_nxt;
  logic [PNB-1:0]            rp_r, rp_nxt;
  logic [LW-1:0]             rl_r, rl_nxt;
  logic [PNB-1:0]            ip_r, ip_nxt;
  logic [LW-1:0]             il_r, il_nxt;
  logic [WW-1:0]             hh_r, hh_nxt;
  logic [WW-1:0]             cur_r, cur_nxt;
  logic [AW:0]               steps_r, steps_nxt;
  logic [WW-1:0]             pr_r, pr_nxt;
  logic [WW-1:0]             nx_r, nx_nxt;
  logic [WW-1:0]             rc_r, rc_nxt;
  logic [LW-1:0]             rco_r, rco_nxt;
  logic [WW-1:0]             rend_r, rend_nxt;
  logic [bpa_pkg::ST_W-1:0]  st_r, st_nxt;
  logic [bpa_pkg::REF_W-1:0] ref_r, ref_nxt;
  logic [PNB-1:0]            page_r, page_nxt;
  logic                      rel_r, rel_nxt;
  logic [WW-1:0]             total_r, total_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [WW-1:0]             heads_r [PNB+1];
  logic [WW-1:0]             heads_nxt [PNB+1];

  logic                      ov_r, ov_nxt;
  logic [bpa_pkg::ST_W-1:0]  os_r, os_nxt;
  logic [PNB-1:0]            opg_r, opg_nxt;
  logic [bpa_pkg::REF_W-1:0] oref_r, oref_nxt;
  logic                      orel_r, orel_nxt;
  logic [WW-1:0]             ofree_r, ofree_nxt;

  function automatic logic f_norm(input logic [WW-1:0] pg, input logic [WW-1:0] zs,
                                  input logic [WW-1:0] ze);
    f_norm = (pg >= zs) && (pg < ze);
  endfunction

  function automatic logic f_present(input logic [WW-1:0] pg, input logic [WW-1:0] pp);
    f_present = (32'(pg) < PAGE_COUNT) && (pg < pp);
  endfunction

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = ov_r;
  assign out_rsp.status     = os_r;
  assign out_rsp.block_page = opg_r;
  assign out_rsp.ref_count  = oref_r;
  assign out_rsp.released   = orel_r;
  assign out_rsp.free_pages = ofree_r;

  always_comb begin
    logic [PNB-1:0]            b_pg;
    logic [WW-1:0]             last_pg;
    logic [WW-1:0]             nrc;
    logic [WW-1:0]             off;
    logic [LW-1:0]             tzv;
    logic [WW:0]               sum;
    logic [WW-1:0]             amt;
    logic [bpa_pkg::REF_W-1:0] ncnt;

    state_nxt = state_r;
    rem_ret_nxt = rem_ret_r;
    ins_ret_nxt = ins_ret_r;
    mrg_ret_nxt = mrg_ret_r;
    op_nxt = op_r;
    ord_nxt = ord_r;
    want_nxt = want_r;
    lvl_nxt = lvl_r;
    mord_nxt = mord_r;
    p_nxt = p_r;
    mh_nxt = mh_r;
    rp_nxt = rp_r;
    rl_nxt = rl_r;
    ip_nxt = ip_r;
    il_nxt = il_r;
    hh_nxt = hh_r;
    cur_nxt = cur_r;
    steps_nxt = steps_r;
    pr_nxt = pr_r;
    nx_nxt = nx_r;
    rc_nxt = rc_r;
    rco_nxt = rco_r;
    rend_nxt = rend_r;
    st_nxt = st_r;
    ref_nxt = ref_r;
    page_nxt = page_r;
    rel_nxt = rel_r;
    total_nxt = total_r;
    clr_nxt = clr_r;
    heads_nxt = heads_r;
    ov_nxt = ov_r && !out_rsp.ready;
    os_nxt = os_r;
    opg_nxt = opg_r;
    oref_nxt = oref_r;
    orel_nxt = orel_r;
    ofree_nxt = ofree_r;

    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_mask = '0;
    wr_nxt = '0;
    wr_prv = '0;
    wr_tag = TAG_ALLOC;
    wr_cnt = '0;

    b_pg = mh_r ^ (PNB'(1) << lvl_r);
    last_pg = rc_r + (WW'(1) << rco_r) - WW'(1);
    nrc = rc_r + (WW'(1) << rco_r);
    off = nrc - {1'b0, p_r};
    tzv = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (off[i]) tzv = LW'(i);
    end
    ncnt = '0;
    sum = '0;
    amt = '0;

    case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_r;
        wr_mask.tag = 1'b1;
        wr_mask.cnt = 1'b1;
        wr_tag = TAG_ALLOC;
        wr_cnt = bpa_pkg::REF_W'(1);
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(PAGE_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt = in_req.operation;
          ord_nxt = LW'(in_req.order);
          want_nxt = in_req.zone;
          p_nxt = in_req.page_number & PNB'(PAGE_COUNT - 1)
                  & ~((PNB'(1) << in_req.order) - PNB'(1));
          st_nxt = bpa_pkg::ST_OK;
          ref_nxt = '0;
          page_nxt = '0;
          rel_nxt = 1'b0;
          if (in_req.operation > bpa_pkg::OP_RELEASE || 32'(in_req.order) > PNB) begin
            st_nxt = bpa_pkg::ST_MISUSE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        case (op_r)
          bpa_pkg::OP_ALLOC: begin
            lvl_nxt = ord_r;
            cur_nxt = heads_r[ord_r];
            steps_nxt = '0;
            state_nxt = S_FIND;
          end
          bpa_pkg::OP_RELEASE: begin
            rc_nxt = {1'b0, p_r};
            rco_nxt = ord_r;
            rend_nxt = {1'b0, p_r} + (WW'(1) << ord_r);
            state_nxt = S_REL_DESC;
          end
          default: begin
            if (!f_present({1'b0, p_r}, present_pages)) begin
              st_nxt = bpa_pkg::ST_ABSENT;
              state_nxt = S_DONE;
            end else begin
              rd_addr = p_r[AW-1:0];
              state_nxt = S_REF;
            end
          end
        endcase
      end
      S_REF: begin
        case (op_r)
          bpa_pkg::OP_REF_GET: begin
            ref_nxt = rd_cnt;
            state_nxt = S_DONE;
          end
          bpa_pkg::OP_REF_INC: begin
            ncnt = (rd_cnt == bpa_pkg::REF_MAX) ? rd_cnt : rd_cnt + bpa_pkg::REF_W'(1);
            wr_en = 1'b1;
            wr_addr = p_r[AW-1:0];
            wr_mask.cnt = 1'b1;
            wr_cnt = ncnt;
            ref_nxt = ncnt;
            state_nxt = S_DONE;
          end
          bpa_pkg::OP_FREE: begin
            if (rd_cnt == '0 || rd_tag != TAG_ALLOC) begin
              st_nxt = bpa_pkg::ST_MISUSE;
              ref_nxt = rd_cnt;
              state_nxt = S_DONE;
            end else begin
              ncnt = rd_cnt - bpa_pkg::REF_W'(1);
              wr_en = 1'b1;
              wr_addr = p_r[AW-1:0];
              wr_mask.cnt = 1'b1;
              wr_cnt = ncnt;
              ref_nxt = ncnt;
              if (ncnt == '0) begin
                rel_nxt = 1'b1;
                mh_nxt = p_r;
                lvl_nxt = ord_r;
                mord_nxt = ord_r;
                mrg_ret_nxt = S_DONE;
                state_nxt = S_M_CHK;
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIND: begin
        if (steps_r == (AW+1)'(PAGE_COUNT) || !cur_r[PNB]) begin
          if (32'(lvl_r) == PNB) begin
            st_nxt = bpa_pkg::ST_NO_FREE;
            state_nxt = S_DONE;
          end else begin
            lvl_nxt = lvl_r + LW'(1);
            cur_nxt = heads_r[lvl_r + LW'(1)];
            steps_nxt = '0;
          end
        end else if (f_norm({1'b0, cur_r[PNB-1:0]}, zone_start_page, zone_end_page)
                     == want_r) begin
          p_nxt = cur_r[PNB-1:0];
          rp_nxt = cur_r[PNB-1:0];
          rl_nxt = lvl_r;
          rem_ret_nxt = S_SPLIT;
          state_nxt = S_RM_RD;
        end else begin
          rd_addr = cur_r[AW-1:0];
          steps_nxt = steps_r + (AW+1)'(1);
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        cur_nxt = rd_nxt;
        state_nxt = S_FIND;
      end
      S_RM_RD: begin
        rd_addr = rp_r[AW-1:0];
        state_nxt = S_RM_LAT;
      end
      S_RM_LAT: begin
        pr_nxt = rd_prv;
        nx_nxt = rd_nxt;
        state_nxt = S_RM_LNK;
      end
      S_RM_LNK: begin
        if (pr_r[PNB]) begin
          wr_en = 1'b1;
          wr_addr = pr_r[AW-1:0];
          wr_mask.nxt = 1'b1;
          wr_nxt = nx_r;
        end else begin
          heads_nxt[rl_r] = nx_r;
        end
        state_nxt = S_RM_PRV;
      end
      S_RM_PRV: begin
        if (nx_r[PNB]) begin
          wr_en = 1'b1;
          wr_addr = nx_r[AW-1:0];
          wr_mask.prv = 1'b1;
          wr_prv = pr_r;
        end
        state_nxt = S_RM_TAG;
      end
      S_RM_TAG: begin
        wr_en = 1'b1;
        wr_addr = rp_r[AW-1:0];
        wr_mask.tag = 1'b1;
        wr_tag = TAG_ALLOC;
        state_nxt = rem_ret_r;
      end
      S_SPLIT: begin
        if (lvl_r > ord_r) begin
          ip_nxt = p_r;
          il_nxt = lvl_r - LW'(1);
          ins_ret_nxt = S_SPLIT;
          p_nxt = p_r ^ (PNB'(1) << (lvl_r - LW'(1)));
          lvl_nxt = lvl_r - LW'(1);
          state_nxt = S_INS_A;
        end else begin
          wr_en = 1'b1;
          wr_addr = p_r[AW-1:0];
          wr_mask.tag = 1'b1;
          wr_mask.cnt = 1'b1;
          wr_tag = TAG_ALLOC;
          wr_cnt = bpa_pkg::REF_W'(1);
          amt = WW'(1) << ord_r;
          total_nxt = (amt > total_r) ? '0 : total_r - amt;
          page_nxt = p_r;
          ref_nxt = bpa_pkg::REF_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_INS_A: begin
        wr_en = 1'b1;
        wr_addr = ip_r[AW-1:0];
        wr_mask.nxt = 1'b1;
        wr_mask.prv = 1'b1;
        wr_mask.tag = 1'b1;
        wr_nxt = heads_r[il_r];
        wr_prv = '0;
        wr_tag = TW'(il_r);
        hh_nxt = heads_r[il_r];
        heads_nxt[il_r] = {1'b1, ip_r};
        state_nxt = S_INS_B;
      end
      S_INS_B: begin
        if (hh_r[PNB]) begin
          wr_en = 1'b1;
          wr_addr = hh_r[AW-1:0];
          wr_mask.prv = 1'b1;
          wr_prv = {1'b1, ip_r};
        end
        state_nxt = ins_ret_r;
      end
      S_M_CHK: begin
        if (32'(lvl_r) < PNB && f_present({1'b0, b_pg}, present_pages)
            && f_norm({1'b0, b_pg}, zone_start_page, zone_end_page)
               == f_norm({1'b0, mh_r}, zone_start_page, zone_end_page)) begin
          rd_addr = b_pg[AW-1:0];
          state_nxt = S_M_TST;
        end else begin
          ip_nxt = mh_r;
          il_nxt = lvl_r;
          ins_ret_nxt = S_M_END;
          state_nxt = S_INS_A;
        end
      end
      S_M_TST: begin
        if (rd_tag == TW'(lvl_r)) begin
          pr_nxt = rd_prv;
          nx_nxt = rd_nxt;
          rp_nxt = b_pg;
          rl_nxt = lvl_r;
          rem_ret_nxt = S_M_NEXT;
          state_nxt = S_RM_LNK;
        end else begin
          ip_nxt = mh_r;
          il_nxt = lvl_r;
          ins_ret_nxt = S_M_END;
          state_nxt = S_INS_A;
        end
      end
      S_M_NEXT: begin
        mh_nxt = mh_r & ~(PNB'(1) << lvl_r);
        lvl_nxt = lvl_r + LW'(1);
        state_nxt = S_M_CHK;
      end
      S_M_END: begin
        sum = {1'b0, total_r} + {1'b0, WW'(1) << mord_r};
        total_nxt = sum[WW] ? {WW{1'b1}} : sum[WW-1:0];
        state_nxt = mrg_ret_r;
      end
      S_REL_DESC: begin
        if (rco_r != '0
            && f_norm(rc_r, zone_start_page, zone_end_page)
               != f_norm(last_pg, zone_start_page, zone_end_page)) begin
          rco_nxt = rco_r - LW'(1);
        end else if (!f_present(rc_r, present_pages)) begin
          if (st_r < bpa_pkg::ST_ABSENT) st_nxt = bpa_pkg::ST_ABSENT;
          state_nxt = S_REL_NEXT;
        end else begin
          rd_addr = rc_r[AW-1:0];
          state_nxt = S_REL_TST;
        end
      end
      S_REL_TST: begin
        if (rd_tag != TAG_ALLOC) begin
          st_nxt = bpa_pkg::ST_MISUSE;
          state_nxt = S_REL_NEXT;
        end else begin
          wr_en = 1'b1;
          wr_addr = rc_r[AW-1:0];
          wr_mask.cnt = 1'b1;
          wr_cnt = '0;
          rel_nxt = 1'b1;
          mh_nxt = rc_r[PNB-1:0];
          lvl_nxt = rco_r;
          mord_nxt = rco_r;
          mrg_ret_nxt = S_REL_NEXT;
          state_nxt = S_M_CHK;
        end
      end
      S_REL_NEXT: begin
        if (nrc == rend_r) begin
          state_nxt = S_DONE;
        end else begin
          rc_nxt = nrc;
          rco_nxt = tzv;
          state_nxt = S_REL_DESC;
        end
      end
      S_DONE: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt = 1'b1;
          os_nxt = st_r;
          opg_nxt = page_r;
          oref_nxt = ref_r;
          orel_nxt = rel_r;
          ofree_nxt = total_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      total_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i <= PNB; i++) heads_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      total_r <= total_nxt;
      ov_r <= ov_nxt;
      heads_r <= heads_nxt;
    end
    rem_ret_r <= rem_ret_nxt;
    ins_ret_r <= ins_ret_nxt;
    mrg_ret_r <= mrg_ret_nxt;
    op_r <= op_nxt;
    ord_r <= ord_nxt;
    want_r <= want_nxt;
    lvl_r <= lvl_nxt;
    mord_r <= mord_nxt;
    p_r <= p_nxt;
    mh_r <= mh_nxt;
    rp_r <= rp_nxt;
    rl_r <= rl_nxt;
    ip_r <= ip_nxt;
    il_r <= il_nxt;
    hh_r <= hh_nxt;
    cur_r <= cur_nxt;
    steps_r <= steps_nxt;
    pr_r <= pr_nxt;
    nx_r <= nx_nxt;
    rc_r <= rc_nxt;
    rco_r <= rco_nxt;
    rend_r <= rend_nxt;
    st_r <= st_nxt;
    ref_r <= ref_nxt;
    page_r <= page_nxt;
    rel_r <= rel_nxt;
    os_r <= os_nxt;
    opg_r <= opg_nxt;
    oref_r <= oref_nxt;
    orel_r <= orel_nxt;
    ofree_r <= ofree_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator: per-order free lists, per-head reference counts,
// configuration registers, sequencer and page table memory.
//
//   channel  dir  handshake       payload
//   in_req   in   valid/ready     operation, page_number, order, zone
//   out_rsp  out  valid/ready     status, block_page, ref_count, released,
//                                 free_pages
//   cfg      in   cfg_wen         cfg_index, cfg_wdata
//
// One request at a time. Ref get, ref inc and a free that keeps its count
// make one table read and at most one write. Alloc walks the list nodes, unlinks
// the block found and splits it order by order; a merge joins buddy orders one by
// one and then links the result, all through the one read and one write port.
// After reset a clearing pass initializes the page table; in_req.ready stays
// low until it ends. A finished result waits in the output register while the
// next request is taken; the one after it stalls until then.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator #(
  parameter int PAGE_NUMBER_BITS = 12,
  parameter int PAGE_COUNT = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  bpa_req_if.sink                             in_req,
  bpa_rsp_if.source                           out_rsp,
  input  wire                                 cfg_wen,
  input  wire  [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [PAGE_NUMBER_BITS:0]           cfg_wdata
);

  localparam int PNB = PAGE_NUMBER_BITS;
  localparam int AW = $clog2(PAGE_COUNT);
  localparam int TW = (PNB < 15) ? 4 : 5;

  logic [PNB:0] present_r;
  logic [PNB:0] zstart_r;
  logic [PNB:0] zend_r;

  logic [AW-1:0]             rd_addr;
  logic [PNB:0]              rd_nxt;
  logic [PNB:0]              rd_prv;
  logic [TW-1:0]             rd_tag;
  logic [bpa_pkg::REF_W-1:0] rd_cnt;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  bpa_pkg::bpa_wmask_t       wr_mask;
  logic [PNB:0]              wr_nxt;
  logic [PNB:0]              wr_prv;
  logic [TW-1:0]             wr_tag;
  logic [bpa_pkg::REF_W-1:0] wr_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= (PNB+1)'(PAGE_COUNT);
      zstart_r <= '0;
      zend_r <= (PNB+1)'(PAGE_COUNT);
    end else if (cfg_wen) begin
      case (cfg_index)
        bpa_pkg::CFG_PRESENT:    present_r <= cfg_wdata;
        bpa_pkg::CFG_ZONE_START: zstart_r <= cfg_wdata;
        bpa_pkg::CFG_ZONE_END:   zend_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpa_ctrl #(
    .PNB        (PNB),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .present_pages   (present_r),
    .zone_start_page (zstart_r),
    .zone_end_page   (zend_r),
    .in_req          (in_req),
    .out_rsp         (out_rsp),
    .rd_addr         (rd_addr),
    .rd_nxt          (rd_nxt),
    .rd_prv          (rd_prv),
    .rd_tag          (rd_tag),
    .rd_cnt          (rd_cnt),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_mask         (wr_mask),
    .wr_nxt          (wr_nxt),
    .wr_prv          (wr_prv),
    .wr_tag          (wr_tag),
    .wr_cnt          (wr_cnt)
  );

  bpa_mem #(
    .AW  (AW),
    .LKW (PNB + 1),
    .TW  (TW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_nxt  (rd_nxt),
    .rd_prv  (rd_prv),
    .rd_tag  (rd_tag),
    .rd_cnt  (rd_cnt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_mask (wr_mask),
    .wr_nxt  (wr_nxt),
    .wr_prv  (wr_prv),
    .wr_tag  (wr_tag),
    .wr_cnt  (wr_cnt)
  );

endmodule

`default_nettype wire
